[rtl/lfu_pkg.sv]
// Package for the LFU cache with LRU tie break.
// Holds word types, controller/datapath link structs and default sizes.
// No dependencies.
package lfu_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CAP_BITS       = 5;
   localparam int KEY_BITS       = 32;
   localparam int DATA_BITS      = 32;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                        func;
      logic [KEY_BITS-1:0]         lookup_key;
      logic signed [DATA_BITS-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic signed [DATA_BITS-1:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic touch;
      logic scan_step;
      logic insert;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic cap_zero;
      logic is_put;
      logic scan_last;
   } status_type;

endpackage

[rtl/lfu_cache_lru_tiebreak.sv]
// LFU cache with LRU tie break: an accepted request word runs a lookup, then a touch on
// a hit, or a victim scan over every entry and an insert on a put miss; a get miss or
// capacity zero goes straight to the result. busy stays high through the result cycle;
// the next word is taken in the cycle after it, so no new word is taken mid-request.
// The receiver cannot stall. Synchronous reset empties the cache and sets capacity to 16.
// Depends on lfu_pkg, lfu_ctrl, lfu_dpath.
module lfu_cache_lru_tiebreak #(
   parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lfu_pkg::req_type              req_word,
   output logic                          rsp_valid,
   output lfu_pkg::rsp_type              rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfu_pkg::CAP_BITS-1:0]  csr_data
);
   import lfu_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   lfu_dpath #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result word outside busy");
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid) else $error("busy held after result");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid) else $error("accept without busy");
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.read_data != '0) |-> rsp_word.found)
      else $error("read data without hit");

endmodule

[rtl/lfu_ctrl.sv]
// Controller for the LFU cache: sequences lookup, touch, victim scan and insert.
// Depends on lfu_pkg.
module lfu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output lfu_pkg::cmd_type    cmd,
   input  lfu_pkg::status_type status
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_TOUCH,
      ST_SCAN,
      ST_INSERT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (status.cap_zero) state_in = ST_RESP;
            else if (status.hit) state_in = ST_TOUCH;
            else if (status.is_put) state_in = ST_SCAN;
            else state_in = ST_RESP;
         end
         ST_TOUCH:  state_in = ST_RESP;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_INSERT;
         end
         ST_INSERT: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.lookup    = (state_ff == ST_LOOK);
      cmd.touch     = (state_ff == ST_TOUCH);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.insert    = (state_ff == ST_INSERT);
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/lfu_dpath.sv]
// Datapath for the LFU cache: entry tags, counts, ranks, data memory, victim scan.
// Depends on lfu_pkg.
module lfu_dpath #(
   parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfu_pkg::req_type              req_word,
   input  logic                          csr_valid,
   input  logic [lfu_pkg::CAP_BITS-1:0]  csr_data,
   input  lfu_pkg::cmd_type              cmd,
   output lfu_pkg::status_type           status,
   output lfu_pkg::rsp_type              rsp_word
);
   import lfu_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   req_type                     req_ff;
   logic [CAP_BITS-1:0]         cap_ff;
   logic [OW-1:0]               occ_ff;
   logic [ENTRIES-1:0]          valid_ff;
   logic [KEY_BITS-1:0]         key_ff  [ENTRIES];
   logic [COUNT_BITS-1:0]       cnt_ff  [ENTRIES];
   logic [IW-1:0]               rank_ff [ENTRIES];
   logic signed [DATA_BITS-1:0] mem     [ENTRIES];
   logic signed [DATA_BITS-1:0] rd_ff;

   logic                        hit_ff;
   logic [IW-1:0]               hit_idx_ff;
   logic [IW-1:0]               scan_idx_ff;
   logic                        vic_found_ff;
   logic [IW-1:0]               vic_idx_ff;
   logic [COUNT_BITS-1:0]       vic_cnt_ff;
   logic [IW-1:0]               vic_rank_ff;
   logic                        free_found_ff;
   logic [IW-1:0]               free_idx_ff;

   logic                        match_any;
   logic [IW-1:0]               match_idx;
   logic [31:0]                 cap_eff;
   logic                        cap_zero;
   logic                        evict;
   logic                        slot_ok;
   logic [IW-1:0]               slot;
   logic                        take_vic;
   logic [COUNT_BITS-1:0]       s_cnt;
   logic [IW-1:0]               s_rank;
   logic                        mem_we;
   logic [IW-1:0]               mem_addr;

   assign cap_eff  = (32'(cap_ff) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_ff);
   assign cap_zero = (cap_ff == '0);

   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == req_ff.lookup_key)) begin
            match_any = 1'b1;
            match_idx = IW'(i);
         end
      end
   end

   assign status.hit       = match_any && !cap_zero;
   assign status.cap_zero  = cap_zero;
   assign status.is_put    = (req_ff.func == FUNC_PUT);
   assign status.scan_last = (32'(scan_idx_ff) == 32'(ENTRIES - 1));

   assign s_cnt    = cnt_ff[scan_idx_ff];
   assign s_rank   = rank_ff[scan_idx_ff];
   assign take_vic = valid_ff[scan_idx_ff] &&
                     (!vic_found_ff || (s_cnt < vic_cnt_ff) ||
                      ((s_cnt == vic_cnt_ff) && (s_rank > vic_rank_ff)));

   assign evict   = (32'(occ_ff) >= cap_eff) && vic_found_ff;
   assign slot_ok = evict || free_found_ff;
   assign slot    = (evict && !(free_found_ff && (free_idx_ff < vic_idx_ff)))
                    ? vic_idx_ff : free_idx_ff;

   assign mem_we   = (cmd.touch && (req_ff.func == FUNC_PUT)) || (cmd.insert && slot_ok);
   assign mem_addr = cmd.insert ? slot : hit_idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= req_ff.write_data;
      rd_ff <= mem[hit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
      if (cmd.lookup) hit_idx_ff <= match_idx;
      if (cmd.scan_step) begin
         if (take_vic) begin
            vic_idx_ff  <= scan_idx_ff;
            vic_cnt_ff  <= s_cnt;
            vic_rank_ff <= s_rank;
         end
         if (!valid_ff[scan_idx_ff] && !free_found_ff) free_idx_ff <= scan_idx_ff;
      end
      if (cmd.touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && (rank_ff[i] < rank_ff[hit_idx_ff])) rank_ff[i] <= rank_ff[i] + 1'b1;
         end
         rank_ff[hit_idx_ff] <= '0;
         if (cnt_ff[hit_idx_ff] != COUNT_MAX) cnt_ff[hit_idx_ff] <= cnt_ff[hit_idx_ff] + 1'b1;
      end
      if (cmd.insert) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && !(evict && (IW'(i) == vic_idx_ff))) begin
               rank_ff[i] <= rank_ff[i] - IW'(evict && (rank_ff[i] > vic_rank_ff))
                             + IW'(slot_ok);
            end
         end
         if (slot_ok) begin
            key_ff[slot]  <= req_ff.lookup_key;
            cnt_ff[slot]  <= COUNT_BITS'(1);
            rank_ff[slot] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_BITS'(16);
         occ_ff        <= '0;
         valid_ff      <= '0;
         hit_ff        <= 1'b0;
         scan_idx_ff   <= '0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (csr_valid) cap_ff <= csr_data;
         if (cmd.lookup) begin
            hit_ff        <= match_any && !cap_zero;
            scan_idx_ff   <= '0;
            vic_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
            if (take_vic) vic_found_ff <= 1'b1;
            if (!valid_ff[scan_idx_ff]) free_found_ff <= 1'b1;
         end
         if (cmd.insert) begin
            if (evict && (slot != vic_idx_ff)) valid_ff[vic_idx_ff] <= 1'b0;
            if (slot_ok) valid_ff[slot] <= 1'b1;
            occ_ff <= occ_ff - OW'(evict) + OW'(slot_ok);
         end
      end
   end

   assign rsp_word.found     = hit_ff;
   assign rsp_word.read_data = (hit_ff && (req_ff.func == FUNC_GET)) ? rd_ff : '0;

endmodule
